// ----- hw/rtl/btpc_pkg.sv -----
// Shared types and constants of the barometric compensation core.
package btpc_pkg;

	localparam int RAW_W   = 24;
	localparam int COEF_W  = 16;
	localparam int VALUE_W = 32;
	localparam int ADDR_W  = 3;

	localparam logic [ADDR_W-1:0] REG_C1 = 3'd0;
	localparam logic [ADDR_W-1:0] REG_C2 = 3'd1;
	localparam logic [ADDR_W-1:0] REG_C3 = 3'd2;
	localparam logic [ADDR_W-1:0] REG_C4 = 3'd3;
	localparam logic [ADDR_W-1:0] REG_C5 = 3'd4;
	localparam logic [ADDR_W-1:0] REG_C6 = 3'd5;

	localparam logic FUNC_TEMP  = 1'b0;
	localparam logic FUNC_PRESS = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T_MC6,
		ST_T_MC4,
		ST_T_MC3,
		ST_T_MDT,
		ST_T_MD,
		ST_T_ME,
		ST_T_CORR,
		ST_T_DONE,
		ST_P_LO,
		ST_P_HI,
		ST_P_ACC,
		ST_P_DIV,
		ST_P_SUB,
		ST_P_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_T_MC6,
		OP_T_MC4,
		OP_T_MC3,
		OP_T_MDT,
		OP_T_MD,
		OP_T_ME,
		OP_T_CORR,
		OP_T_DONE,
		OP_P_LO,
		OP_P_HI,
		OP_P_ACC,
		OP_P_DIV,
		OP_P_SUB,
		OP_P_DONE
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

endpackage

// ----- hw/rtl/baro_temp_pressure_compensation_core.sv -----
// Top level of the barometric temperature and pressure compensation core.
// One request is in work at a time; temperature and pressure requests each step through
// their own sequence of passes through the one shared 26 by 26 bit multiplier.
// A finished result waits in the output register while the next request is taken.
// The asynchronous reset clears the coefficients, the stored offset and sensitivity, and control.
module baro_temp_pressure_compensation_core import btpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [RAW_W-1:0]   s_tdata,   // raw_sample
	input  logic               s_tuser,   // func
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,   // value
	output logic               m_tuser,   // kind
	input  logic               cfg_we,
	input  logic [ADDR_W-1:0]  cfg_addr,
	input  logic [COEF_W-1:0]  cfg_wdata
);

	cmd_t cmd;

	btpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	btpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.raw_in    (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_kind  (m_tuser),
		.out_value (m_tdata)
	);

endmodule

// ----- hw/rtl/btpc_ctrl.sv -----
// Sequencer that steps the datapath through the temperature and pressure computations.
module btpc_ctrl import btpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   done_fire;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		done_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = (s_tuser == FUNC_PRESS) ? ST_P_LO : ST_T_MC6;
				end
			end
			ST_T_MC6: begin
				cmd.op  = OP_T_MC6;
				state_d = ST_T_MC4;
			end
			ST_T_MC4: begin
				cmd.op  = OP_T_MC4;
				state_d = ST_T_MC3;
			end
			ST_T_MC3: begin
				cmd.op  = OP_T_MC3;
				state_d = ST_T_MDT;
			end
			ST_T_MDT: begin
				cmd.op  = OP_T_MDT;
				state_d = ST_T_MD;
			end
			ST_T_MD: begin
				cmd.op  = OP_T_MD;
				state_d = ST_T_ME;
			end
			ST_T_ME: begin
				cmd.op  = OP_T_ME;
				state_d = ST_T_CORR;
			end
			ST_T_CORR: begin
				cmd.op  = OP_T_CORR;
				state_d = ST_T_DONE;
			end
			ST_T_DONE: begin
				if (out_free) begin
					cmd.op    = OP_T_DONE;
					done_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_P_LO: begin
				cmd.op  = OP_P_LO;
				state_d = ST_P_HI;
			end
			ST_P_HI: begin
				cmd.op  = OP_P_HI;
				state_d = ST_P_ACC;
			end
			ST_P_ACC: begin
				cmd.op  = OP_P_ACC;
				state_d = ST_P_DIV;
			end
			ST_P_DIV: begin
				cmd.op  = OP_P_DIV;
				state_d = ST_P_SUB;
			end
			ST_P_SUB: begin
				cmd.op  = OP_P_SUB;
				state_d = ST_P_DONE;
			end
			ST_P_DONE: begin
				if (out_free) begin
					cmd.op    = OP_P_DONE;
					done_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/btpc_dp.sv -----
// Datapath with coefficient registers, a shared multiplier and the compensation arithmetic.
module btpc_dp import btpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [RAW_W-1:0]    raw_in,
	input  logic                cfg_we,
	input  logic [ADDR_W-1:0]   cfg_addr,
	input  logic [COEF_W-1:0]   cfg_wdata,
	output logic                out_kind,
	output logic [VALUE_W-1:0]  out_value
);

	logic [COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	logic [RAW_W-1:0]    raw_q;
	logic signed [24:0]  dt_q;
	logic signed [19:0]  temp_q;
	logic signed [19:0]  t2_q;
	logic signed [47:0]  off_q;
	logic signed [47:0]  sens_q;
	logic signed [47:0]  off2_q;
	logic signed [47:0]  sens2_q;
	logic signed [47:0]  off_st_q;
	logic signed [47:0]  sens_st_q;
	logic signed [72:0]  acc_q;
	logic signed [51:0]  quo_q;
	logic signed [52:0]  diff_q;
	logic signed [51:0]  prod_q;
	logic                out_kind_q;
	logic [VALUE_W-1:0]  out_value_q;

	logic signed [25:0]  mul_a;
	logic signed [25:0]  mul_b;
	logic signed [20:0]  d_w;
	logic signed [20:0]  e_w;
	logic                lt_ref;
	logic                lt_low;
	logic signed [54:0]  prod5;
	logic signed [54:0]  prod7;
	logic signed [54:0]  prod11;
	logic signed [72:0]  acc_bias;
	logic signed [52:0]  diff_bias;
	logic signed [52:0]  press_w;

	function automatic logic signed [51:0] shr_trunc(input logic signed [51:0] x,
		input logic [5:0] sh);
		logic signed [51:0] bias;
		bias = x[51] ? ((52'sd1 <<< sh) - 52'sd1) : 52'sd0;
		return (x + bias) >>> sh;
	endfunction

	assign d_w    = $signed({temp_q[19], temp_q}) - 21'sd2000;
	assign e_w    = $signed({temp_q[19], temp_q}) + 21'sd1500;
	assign lt_ref = (temp_q < 20'sd2000);
	assign lt_low = (temp_q < -20'sd1500);

	assign prod5  = (55'(prod_q) <<< 2) + 55'(prod_q);
	assign prod7  = (55'(prod_q) <<< 3) - 55'(prod_q);
	assign prod11 = (55'(prod_q) <<< 3) + (55'(prod_q) <<< 1) + 55'(prod_q);

	assign acc_bias  = acc_q[72] ? 73'sd2097151 : 73'sd0;
	assign diff_bias = diff_q[52] ? 53'sd32767 : 53'sd0;
	assign press_w   = (diff_q + diff_bias) >>> 15;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_T_MC6: begin
				mul_a = $signed({dt_q[24], dt_q});
				mul_b = $signed({10'd0, c6_q});
			end
			OP_T_MC4: begin
				mul_a = $signed({dt_q[24], dt_q});
				mul_b = $signed({10'd0, c4_q});
			end
			OP_T_MC3: begin
				mul_a = $signed({dt_q[24], dt_q});
				mul_b = $signed({10'd0, c3_q});
			end
			OP_T_MDT: begin
				mul_a = $signed({dt_q[24], dt_q});
				mul_b = $signed({dt_q[24], dt_q});
			end
			OP_T_MD: begin
				mul_a = $signed({{5{d_w[20]}}, d_w});
				mul_b = $signed({{5{d_w[20]}}, d_w});
			end
			OP_T_ME: begin
				mul_a = $signed({{5{e_w[20]}}, e_w});
				mul_b = $signed({{5{e_w[20]}}, e_w});
			end
			OP_P_LO: begin
				mul_a = $signed({2'd0, raw_q});
				mul_b = $signed({2'd0, sens_st_q[23:0]});
			end
			OP_P_HI: begin
				mul_a = $signed({2'd0, raw_q});
				mul_b = $signed({{2{sens_st_q[47]}}, sens_st_q[47:24]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q      <= '0;
			c2_q      <= '0;
			c3_q      <= '0;
			c4_q      <= '0;
			c5_q      <= '0;
			c6_q      <= '0;
			off_st_q  <= '0;
			sens_st_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_C1: c1_q <= cfg_wdata;
					REG_C2: c2_q <= cfg_wdata;
					REG_C3: c3_q <= cfg_wdata;
					REG_C4: c4_q <= cfg_wdata;
					REG_C5: c5_q <= cfg_wdata;
					REG_C6: c6_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (cmd.op == OP_T_DONE) begin
				off_st_q  <= off_q - off2_q;
				sens_st_q <= sens_q - sens2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: begin
				raw_q <= raw_in;
				dt_q  <= $signed({1'b0, raw_in}) - $signed({1'b0, c5_q, 8'd0});
			end
			OP_T_MC4: begin
				temp_q <= 20'(shr_trunc(prod_q, 6'd23) + 52'sd2000);
			end
			OP_T_MC3: begin
				off_q <= 48'(shr_trunc(prod_q, 6'd7) + $signed({20'd0, c2_q, 16'd0}));
			end
			OP_T_MDT: begin
				sens_q <= 48'(shr_trunc(prod_q, 6'd8) + $signed({21'd0, c1_q, 15'd0}));
			end
			OP_T_MD: begin
				t2_q <= lt_ref ? 20'(prod_q >>> 31) : 20'sd0;
			end
			OP_T_ME: begin
				off2_q  <= lt_ref ? 48'(prod5 >>> 1) : 48'sd0;
				sens2_q <= lt_ref ? 48'(prod5 >>> 2) : 48'sd0;
			end
			OP_T_CORR: begin
				if (lt_low) begin
					off2_q  <= off2_q + 48'(prod7);
					sens2_q <= sens2_q + 48'(prod11 >>> 1);
				end
			end
			OP_T_DONE: begin
				out_kind_q  <= FUNC_TEMP;
				out_value_q <= 32'($signed({temp_q[19], temp_q}) - $signed({t2_q[19], t2_q}));
			end
			OP_P_HI: begin
				acc_q <= 73'(prod_q);
			end
			OP_P_ACC: begin
				acc_q <= acc_q + (73'(prod_q) <<< 24);
			end
			OP_P_DIV: begin
				quo_q <= 52'((acc_q + acc_bias) >>> 21);
			end
			OP_P_SUB: begin
				diff_q <= 53'(quo_q) - 53'(off_st_q);
			end
			OP_P_DONE: begin
				out_kind_q <= FUNC_PRESS;
				if (press_w > 53'sd2147483647) begin
					out_value_q <= 32'h7fff_ffff;
				end else if (press_w < -53'sd2147483648) begin
					out_value_q <= 32'h8000_0000;
				end else begin
					out_value_q <= press_w[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_kind  = out_kind_q;
	assign out_value = out_value_q;

endmodule

// ----- hw/rtl/btpc_chk.sv -----
// Port-level checker for the compensation core and its bind.
module btpc_chk import btpc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               s_tuser,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [VALUE_W-1:0] m_tdata,
	input logic               m_tuser
);

	// A held result keeps its payload until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

	// Only one request is in work at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while busy");

	// A temperature request into an empty output gives its result after a fixed latency.
	a_temp_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == FUNC_TEMP) && !m_tvalid) |->
		##9 (m_tvalid && (m_tuser == FUNC_TEMP)))
		else $error("temperature result missing or late");

	// A pressure request into an empty output gives its result after a fixed latency.
	a_press_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == FUNC_PRESS) && !m_tvalid) |->
		##7 (m_tvalid && (m_tuser == FUNC_PRESS)))
		else $error("pressure result missing or late");

endmodule

bind baro_temp_pressure_compensation_core btpc_chk u_btpc_chk (.*);

// ----- tb/baro_temp_pressure_compensation_core_tb.sv -----
// Self-checking testbench for the barometric temperature and pressure compensation core.
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_core_tb;
	import btpc_pkg::*;

	localparam longint TEMP_REF    = 64'sd2000;
	localparam longint TEMP_LOW    = -64'sd1500;
	localparam longint TEMP_DIV    = 64'sd8388608;
	localparam longint T2_DIV      = 64'sd2147483648;
	localparam longint P_SENS_DIV  = 64'sd2097152;
	localparam longint P_FINAL_DIV = 64'sd32768;
	localparam longint RAW_MAX     = 64'sd16777215;
	localparam longint VAL_MAX     = 64'sd2147483647;
	localparam longint VAL_MIN     = -64'sd2147483648;
	localparam int     STALL_LIMIT = 4000;
	localparam int     RANDOM_PER_PHASE = 240;

	typedef struct packed {
		logic             func;
		logic [RAW_W-1:0] raw;
	} sample_t;

	typedef struct packed {
		logic               kind;
		logic [VALUE_W-1:0] value;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [RAW_W-1:0]   s_tdata = '0;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [VALUE_W-1:0] m_tdata;
	logic               m_tuser;
	logic               cfg_we = 1'b0;
	logic [ADDR_W-1:0]  cfg_addr = '0;
	logic [COEF_W-1:0]  cfg_wdata = '0;

	sample_t pending_requests[$];
	result_t expected_results[$];

	logic [COEF_W-1:0] coef_shadow [0:5] = '{default: '0};
	longint stored_offset = 0;
	longint stored_sensitivity = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int stall_cycles = 0;

	baro_temp_pressure_compensation_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t compensate_sample(input logic func, input logic [RAW_W-1:0] raw);
		longint dt, temp_c, off, sens, t2, off2, sens2, d, e, v;
		result_t res;
		if (func == FUNC_TEMP) begin
			dt = longint'(raw) - longint'(coef_shadow[REG_C5]) * 256;
			temp_c = TEMP_REF + dt * longint'(coef_shadow[REG_C6]) / TEMP_DIV;
			off = longint'(coef_shadow[REG_C2]) * 65536 + (longint'(coef_shadow[REG_C4]) * dt) / 128;
			sens = longint'(coef_shadow[REG_C1]) * 32768 + (longint'(coef_shadow[REG_C3]) * dt) / 256;
			t2 = 0;
			off2 = 0;
			sens2 = 0;
			if (temp_c < TEMP_REF) begin
				d = temp_c - TEMP_REF;
				t2 = dt * dt / T2_DIV;
				off2 = 5 * (d * d) / 2;
				sens2 = 5 * (d * d) / 4;
				if (temp_c < TEMP_LOW) begin
					e = temp_c - TEMP_LOW;
					off2 = off2 + 7 * e * e;
					sens2 = sens2 + 11 * e * e / 2;
				end
			end
			stored_offset = off - off2;
			stored_sensitivity = sens - sens2;
			v = temp_c - t2;
		end else begin
			v = (longint'(raw) * stored_sensitivity / P_SENS_DIV - stored_offset) / P_FINAL_DIV;
		end
		if (v > VAL_MAX)
			v = VAL_MAX;
		else if (v < VAL_MIN)
			v = VAL_MIN;
		res.kind = func;
		res.value = v[VALUE_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(compensate_sample(s_tuser, s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.raw;
					s_tuser <= nxt.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d value %0d", m_tuser, $signed(m_tdata));
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.kind) begin
						$error("kind mismatch: expected %0d, got %0d", want.kind, m_tuser);
						error_count++;
					end
					if (m_tdata !== want.value) begin
						$error("value mismatch: expected %0d, got %0d",
							$signed(want.value), $signed(m_tdata));
						error_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(pending_requests.size() == 0 && !s_tvalid && expected_results.size() == 0)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("** baro_temp_pressure_compensation_core: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_sample(input logic func, input logic [RAW_W-1:0] raw);
		sample_t s;
		s.func = func;
		s.raw = raw;
		pending_requests.push_back(s);
	endtask

	task automatic write_coef(input logic [ADDR_W-1:0] addr, input logic [COEF_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		coef_shadow[addr] = val;
	endtask

	task automatic load_coefs(input logic [COEF_W-1:0] v1, v2, v3, v4, v5, v6);
		write_coef(REG_C1, v1);
		write_coef(REG_C2, v2);
		write_coef(REG_C3, v3);
		write_coef(REG_C4, v4);
		write_coef(REG_C5, v5);
		write_coef(REG_C6, v6);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	function automatic logic [RAW_W-1:0] temp_raw();
		longint r;
		longint span;
		if ($urandom_range(3) == 0)
			return RAW_W'($urandom);
		span = longint'($urandom_range(0, 1 << $urandom_range(4, 23)));
		r = longint'(coef_shadow[REG_C5]) * 256 + ($urandom_range(1) ? span : -span);
		if (r < 0)
			r = 0;
		if (r > RAW_MAX)
			r = RAW_MAX;
		return r[RAW_W-1:0];
	endfunction

	function automatic logic [RAW_W-1:0] press_raw();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	task automatic queue_random_items(input int count);
		int n;
		int run;
		n = 0;
		while (n < count) begin
			if ($urandom_range(99) < 75) begin
				push_sample(FUNC_TEMP, temp_raw());
				run = $urandom_range(1, 4);
				for (int i = 0; i < run; i++)
					push_sample(FUNC_PRESS, press_raw());
				n += run + 1;
			end else begin
				push_sample(($urandom_range(1) != 0) ? FUNC_PRESS : FUNC_TEMP, RAW_W'($urandom));
				n++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 13;
		recv_idle_pct = 49;

		// Pressure before any temperature sample, with cleared coefficients.
		@(negedge clk);
		push_sample(FUNC_PRESS, 24'h000000);
		push_sample(FUNC_PRESS, 24'hFFFFFF);
		push_sample(FUNC_TEMP, 24'h000000);
		push_sample(FUNC_PRESS, 24'hFFFFFF);
		drain();

		load_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
		@(negedge clk);
		push_sample(FUNC_TEMP, 24'd8566784);
		push_sample(FUNC_PRESS, 24'hFFFFFF);
		push_sample(FUNC_TEMP, 24'd8566783);
		push_sample(FUNC_PRESS, 24'h000000);
		push_sample(FUNC_TEMP, 24'd8566487);
		push_sample(FUNC_PRESS, 24'd9085466);
		push_sample(FUNC_TEMP, 24'd7529763);
		push_sample(FUNC_PRESS, 24'd9085466);
		push_sample(FUNC_TEMP, 24'd7529000);
		push_sample(FUNC_PRESS, 24'hFFFFFF);
		push_sample(FUNC_TEMP, 24'h000000);
		push_sample(FUNC_PRESS, 24'hFFFFFF);
		push_sample(FUNC_PRESS, 24'h000000);
		push_sample(FUNC_TEMP, 24'hFFFFFF);
		push_sample(FUNC_PRESS, 24'd9085466);
		push_sample(FUNC_TEMP, 24'd8077636);
		push_sample(FUNC_PRESS, 24'd6465444);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: load_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
				1: load_coefs('1, '1, '1, '1, '1, '1);
				3: load_coefs('1, '1, '1, '1, '0, '1);
				5: load_coefs('0, '0, '0, '0, '0, '0);
				default: load_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
					COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
			endcase
			@(negedge clk);
			if (phase < 2) begin
				send_idle_pct = 13;
				recv_idle_pct = 49;
			end else if (phase < 4) begin
				send_idle_pct = 49;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			queue_random_items(RANDOM_PER_PHASE);
			drain();
		end

		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("** baro_temp_pressure_compensation_core: PASSED **");
		else
			$display("** baro_temp_pressure_compensation_core: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_ctrl.sv
hw/rtl/btpc_dp.sv
hw/rtl/baro_temp_pressure_compensation_core.sv
hw/rtl/btpc_chk.sv
tb/baro_temp_pressure_compensation_core_tb.sv
